@@ rtl/core/evi_pkg.sv @@
// Package for the eased value interpolator: payload structs, fixed-point
// constants, register indexes and the quarter-sine table.
// No dependencies.
package evi_pkg;

  localparam int SINE_ROM_ENTRIES   = 256;
  localparam int PROGRESS_FRAC_BITS = 16;

  localparam int PROG_W      = PROGRESS_FRAC_BITS + 1;
  localparam int SINE_IDX_W  = $clog2(SINE_ROM_ENTRIES) + 1;
  localparam int SINE_SHIFT  = $clog2(SINE_ROM_ENTRIES);

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 54;
  localparam int DIV_R_W = 31;

  localparam logic [PROG_W-1:0] PROG_ONE  = PROG_W'(1) << PROGRESS_FRAC_BITS;
  localparam logic [30:0]       Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0]       HALF_PI   = 31'd1686629713;
  localparam logic [31:0]       PI_Q30    = 32'd3373259426;
  localparam logic [31:0]       INV_SIN2  = 32'd1180847754;

  localparam logic CFG_CURVE_MODE = 1'b0;
  localparam logic CFG_RATE       = 1'b1;

  localparam logic [2:0] CURVE_LINEAR = 3'd0;
  localparam logic [2:0] CURVE_SQUARE = 3'd1;
  localparam logic [2:0] CURVE_CUBIC  = 3'd2;
  localparam logic [2:0] CURVE_QSINE  = 3'd3;
  localparam logic [2:0] CURVE_SIN2X  = 3'd4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] start_value;
    logic signed [31:0] target_value;
    logic        [23:0] delta;
  } evi_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               changed;
    logic               finished;
  } evi_out_t;

  typedef logic [30:0] sine_tab_t [SINE_ROM_ENTRIES+1];

  function automatic logic [30:0] taylor_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    return 31'(sum);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int k = 0; k <= SINE_ROM_ENTRIES; k++) begin
      t[k] = taylor_sin((64'(HALF_PI) * 64'(k)) / 64'(SINE_ROM_ENTRIES));
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine();

endpackage

@@ rtl/core/evi_serial_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on evi_pkg.
module evi_serial_mul import evi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               run;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_P_W-1:0] acc;
  logic [MUL_A_W:0]   sum;

  assign sum     = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (acc[0] ? {1'b0, a_r} : '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      acc <= {{MUL_A_W{1'b0}}, b};
    end else if (run) begin
      acc <= {sum, acc[MUL_B_W-1:1]};
    end
  end

endmodule

@@ rtl/core/evi_serial_div.sv @@
// Restoring divider by the constant pi/2 in Q30, one quotient bit per cycle.
// Depends on evi_pkg.
module evi_serial_div import evi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient,
  output logic [DIV_R_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               run;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_R_W-1:0] r;
  logic [DIV_N_W-1:0] n;
  logic [DIV_R_W:0]   r_sh;
  logic [DIV_R_W:0]   r_sub;
  logic               ge;

  assign r_sh      = {r, n[DIV_N_W-1]};
  assign ge        = r_sh >= {1'b0, HALF_PI};
  assign r_sub     = r_sh - {1'b0, HALF_PI};
  assign quotient  = n;
  assign remainder = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift dividend bits out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      n <= dividend;
    end else if (run) begin
      r <= ge ? r_sub[DIV_R_W-1:0] : r_sh[DIV_R_W-1:0];
      n <= {n[DIV_N_W-2:0], ge};
    end
  end

endmodule

@@ rtl/core/eased_value_interpolator_core.sv @@
// Eased value interpolator core: sequencer, state, output register.
// Depends on evi_pkg, evi_serial_mul and evi_serial_div.
//
// Usage: a start item (cmd 0) loads start and target values and begins a run;
// a tick item (cmd 1) advances progress by delta * rate and returns the eased
// value start + span * curve(progress), saturated to Q16.16. Every item gives
// exactly one result. Items enter on in_valid/in_ready, results leave on
// out_valid/out_ready, and cfg_valid/cfg_index/cfg_data write curve_mode and
// rate (cfg_ready is always high; write only while idle).
// Start items, idle ticks and the final snap tick skip the arithmetic units.
// A moving tick runs through one serial multiply for the step, up to two
// more for the curve, and one for the span; the sine curves use up to two
// multiplies and two serial divisions for the curve.
// One item is worked at a time. The result sits in an output register, so
// the next item is accepted while a stalled result waits; a second result
// waits in the sequencer until the register frees.
// Reset clears the run state, curve_mode to linear and rate to 1.0.
module eased_value_interpolator_core import evi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  evi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output evi_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int STEP_LSB  = 32 - PROGRESS_FRAC_BITS;
  localparam int STEP_W    = 48 - STEP_LSB;
  localparam int P30_SHIFT = 30 - PROGRESS_FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP, S_SQ, S_CQ1, S_CQ2, S_TH, S_SIN, S_IDX,
    S_RDA, S_RDB, S_DIFF, S_IMUL, S_IDIV, S_POST, S_SCALE, S_CURVE,
    S_FIN, S_DONE
  } state_t;

  state_t state;

  logic [2:0]  curve_mode;
  logic [23:0] rate;

  logic               running;
  logic [PROG_W-1:0]  prog;
  logic signed [31:0] origin_value;
  logic signed [32:0] span;
  logic signed [31:0] goal_value;
  logic signed [31:0] present_value;
  logic               res_changed;
  logic               res_finished;

  logic [30:0]           curve;
  logic [31:0]           theta;
  logic [30:0]           qv;
  logic [30:0]           sin_a;
  logic [30:0]           sin_b;
  logic [SINE_IDX_W-1:0] idx;
  logic [DIV_R_W-1:0]    rem;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_p;

  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;
  logic [DIV_R_W-1:0] div_r;

  evi_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  evi_serial_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // progress update
  logic [STEP_W:0]     prog_sum;
  logic [PROG_W-1:0]   prog_new;
  logic [30:0]         p30n;
  assign prog_sum = {1'b0, mul_p[47:STEP_LSB]} + (STEP_W+1)'(prog);
  assign prog_new = (prog_sum > (STEP_W+1)'(PROG_ONE)) ? PROG_ONE : prog_sum[PROG_W-1:0];
  assign p30n     = 31'(prog_new) << P30_SHIFT;

  // angle fold into the first quadrant
  logic [31:0] th_c;
  logic [30:0] th_r;
  assign th_c = (theta > PI_Q30) ? PI_Q30 : theta;
  assign th_r = (th_c > {1'b0, HALF_PI}) ? 31'(PI_Q30 - th_c) : th_c[30:0];

  // span magnitude and final sum
  logic        span_neg;
  logic [32:0] span_mag;
  logic [34:0] scaled;
  logic signed [35:0] total;
  assign span_neg = span[32];
  assign span_mag = span_neg ? 33'(-span) : 33'(span);
  assign scaled   = mul_p[64:30];
  assign total    = 36'(origin_value) +
                    (span_neg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled}));

  logic signed [31:0] sat_value;
  always_comb begin
    if (total > 36'sh0_7FFF_FFFF)       sat_value = 32'sh7FFF_FFFF;
    else if (total < -36'sh0_8000_0000) sat_value = 32'sh8000_0000;
    else                                sat_value = total[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= CURVE_LINEAR;
      rate       <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURVE_MODE: curve_mode <= cfg_data[2:0];
        CFG_RATE:       rate       <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      prog          <= '0;
      origin_value  <= '0;
      span          <= '0;
      goal_value    <= '0;
      present_value <= '0;
      res_changed   <= 1'b0;
      res_finished  <= 1'b0;
      mul_start     <= 1'b0;
      div_start     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_changed  <= 1'b0;
            res_finished <= 1'b0;
            if (in_data.cmd == CMD_START) begin
              origin_value  <= in_data.start_value;
              goal_value    <= in_data.target_value;
              span          <= 33'(in_data.target_value) - 33'(in_data.start_value);
              present_value <= in_data.start_value;
              prog          <= '0;
              running       <= 1'b1;
              state         <= S_DONE;
            end else if (!running) begin
              state <= S_DONE;
            end else if (prog < PROG_ONE) begin
              mul_a     <= MUL_A_W'(in_data.delta);
              mul_b     <= MUL_B_W'(rate);
              mul_start <= 1'b1;
              state     <= S_STEP;
            end else begin
              if (present_value != goal_value) begin
                present_value <= goal_value;
                res_changed   <= 1'b1;
                res_finished  <= 1'b1;
              end
              running <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_STEP: begin
          if (mul_done) begin
            prog <= prog_new;
            case (curve_mode)
              CURVE_SQUARE: begin
                mul_a     <= MUL_A_W'(p30n);
                mul_b     <= MUL_B_W'(p30n);
                mul_start <= 1'b1;
                state     <= S_SQ;
              end
              CURVE_CUBIC: begin
                qv        <= Q30_ONE - p30n;
                mul_a     <= MUL_A_W'(Q30_ONE - p30n);
                mul_b     <= MUL_B_W'(Q30_ONE - p30n);
                mul_start <= 1'b1;
                state     <= S_CQ1;
              end
              CURVE_QSINE: begin
                mul_a     <= MUL_A_W'(p30n);
                mul_b     <= MUL_B_W'(HALF_PI);
                mul_start <= 1'b1;
                state     <= S_TH;
              end
              CURVE_SIN2X: begin
                theta <= {p30n, 1'b0};
                state <= S_SIN;
              end
              default: begin
                curve <= p30n;
                state <= S_CURVE;
              end
            endcase
          end
        end
        S_SQ: begin
          if (mul_done) begin
            curve <= mul_p[60:30];
            state <= S_CURVE;
          end
        end
        S_CQ1: begin
          if (mul_done) begin
            mul_a     <= MUL_A_W'(mul_p[60:30]);
            mul_b     <= MUL_B_W'(qv);
            mul_start <= 1'b1;
            state     <= S_CQ2;
          end
        end
        S_CQ2: begin
          if (mul_done) begin
            curve <= Q30_ONE - mul_p[60:30];
            state <= S_CURVE;
          end
        end
        S_TH: begin
          if (mul_done) begin
            theta <= {1'b0, mul_p[60:30]};
            state <= S_SIN;
          end
        end
        S_SIN: begin
          div_n     <= DIV_N_W'(th_r) << SINE_SHIFT;
          div_start <= 1'b1;
          state     <= S_IDX;
        end
        S_IDX: begin
          if (div_done) begin
            idx <= div_q[SINE_IDX_W-1:0];
            rem <= div_r;
            if (div_q[SINE_IDX_W-1]) begin
              sin_a <= SINE_ROM[SINE_ROM_ENTRIES];
              state <= S_POST;
            end else begin
              state <= S_RDA;
            end
          end
        end
        S_RDA: begin
          sin_a <= SINE_ROM[idx];
          state <= S_RDB;
        end
        S_RDB: begin
          sin_b <= SINE_ROM[SINE_IDX_W'(idx + 1'b1)];
          state <= S_DIFF;
        end
        S_DIFF: begin
          mul_a     <= MUL_A_W'(sin_b - sin_a);
          mul_b     <= MUL_B_W'(rem);
          mul_start <= 1'b1;
          state     <= S_IMUL;
        end
        S_IMUL: begin
          if (mul_done) begin
            div_n     <= mul_p[DIV_N_W-1:0];
            div_start <= 1'b1;
            state     <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            sin_a <= sin_a + div_q[30:0];
            state <= S_POST;
          end
        end
        S_POST: begin
          if (curve_mode == CURVE_SIN2X) begin
            mul_a     <= MUL_A_W'(sin_a);
            mul_b     <= INV_SIN2;
            mul_start <= 1'b1;
            state     <= S_SCALE;
          end else begin
            curve <= sin_a;
            state <= S_CURVE;
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            curve <= mul_p[60:30];
            state <= S_CURVE;
          end
        end
        S_CURVE: begin
          mul_a     <= span_mag;
          mul_b     <= MUL_B_W'(curve);
          mul_start <= 1'b1;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (mul_done) begin
            present_value <= sat_value;
            res_changed   <= 1'b1;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register frees
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.value    <= present_value;
      out_data.changed  <= res_changed;
      out_data.finished <= res_finished;
    end
  end

  a_prog_bounded: assert property (@(posedge clk) disable iff (rst)
    prog <= PROG_ONE)
    else $error("progress above one");

  a_finish_moves: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.changed || !out_data.finished))
    else $error("finished without a change");

  a_done_units_idle: assert property (@(posedge clk) disable iff (rst)
    (mul_done || div_done) |-> (state != S_IDLE && state != S_DONE))
    else $error("arithmetic unit finished outside a run");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for eased_value_interpolator_core: an in-bench model of the
// easing curves predicts every result. Depends on evi_pkg and the core RTL.
module tb_top;
  import evi_pkg::*;

  localparam longint unsigned Q30_UNIT   = 64'd1 << 30;
  localparam longint unsigned HALF_PI_TB = 64'd1686629713;
  localparam longint unsigned PI_TB      = 64'd3373259426;
  localparam longint unsigned INV_SIN2_TB = 64'd1180847754;
  localparam longint unsigned PROG_FULL  = 64'd1 << PROGRESS_FRAC_BITS;
  localparam int              CYCLE_LIMIT = 4000000;
  localparam int              RANDOM_ITEMS = 1750;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  evi_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  evi_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_index = CFG_CURVE_MODE;
  logic [23:0] cfg_data = '0;

  eased_value_interpolator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // model state
  logic [30:0]        sine_q30 [SINE_ROM_ENTRIES+1];
  logic [2:0]         curve_sel;
  logic [23:0]        rate_q;
  bit                 run_active;
  longint unsigned    progress_q;
  logic signed [31:0] origin_q, goal_q, present_q;
  longint             span_q;

  evi_out_t pending_values[$];
  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  steady = 1'b0;

  function automatic longint unsigned series_sine(longint unsigned x);
    longint unsigned x2, term, div;
    longint          acc;
    x2  = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      div  = longint'((2 * i) * (2 * i + 1));
      term = ((term * x2) >> 30) / div;
      if (i % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q30_UNIT)) acc = longint'(Q30_UNIT);
    return longint'(acc);
  endfunction

  function automatic longint unsigned sine_lookup(longint unsigned th);
    longint unsigned scaled, idx, rem;
    longint          a, b;
    if (th > PI_TB) th = PI_TB;
    if (th > HALF_PI_TB) th = PI_TB - th;
    scaled = th * SINE_ROM_ENTRIES;
    idx = scaled / HALF_PI_TB;
    rem = scaled % HALF_PI_TB;
    if (idx >= SINE_ROM_ENTRIES) return sine_q30[SINE_ROM_ENTRIES];
    a = longint'(sine_q30[idx]);
    b = longint'(sine_q30[idx+1]);
    return a + ((b - a) * longint'(rem)) / longint'(HALF_PI_TB);
  endfunction

  function automatic longint unsigned eased_fraction();
    longint unsigned p30, q, q2;
    p30 = progress_q << (30 - PROGRESS_FRAC_BITS);
    case (curve_sel)
      CURVE_SQUARE: return (p30 * p30) >> 30;
      CURVE_CUBIC: begin
        q  = Q30_UNIT - p30;
        q2 = (q * q) >> 30;
        return Q30_UNIT - ((q2 * q) >> 30);
      end
      CURVE_QSINE: return sine_lookup((p30 * HALF_PI_TB) >> 30);
      CURVE_SIN2X: return (sine_lookup(2 * p30) * INV_SIN2_TB) >> 30;
      default: return p30;
    endcase
  endfunction

  function automatic evi_out_t advance_value(evi_in_t it);
    evi_out_t r;
    longint unsigned stepv;
    longint acc;
    r = '0;
    if (it.cmd == CMD_START) begin
      origin_q = it.start_value;
      goal_q = it.target_value;
      span_q = longint'(goal_q) - longint'(origin_q);
      present_q = origin_q;
      progress_q = 0;
      run_active = 1'b1;
    end else if (run_active) begin
      if (progress_q < PROG_FULL) begin
        stepv = (longint'(it.delta) * longint'(rate_q)) >> (32 - PROGRESS_FRAC_BITS);
        progress_q = progress_q + stepv;
        if (progress_q > PROG_FULL) progress_q = PROG_FULL;
        acc = longint'(origin_q) + (span_q * longint'(eased_fraction())) / longint'(Q30_UNIT);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        present_q = acc[31:0];
        r.changed = 1'b1;
      end else begin
        if (present_q != goal_q) begin
          present_q = goal_q;
          r.changed = 1'b1;
          r.finished = 1'b1;
        end
        run_active = 1'b0;
      end
    end
    r.value = present_q;
    return r;
  endfunction

  // output side: random backpressure (none while steady), check each transfer
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result value=%h changed=%b finished=%b",
                 $time, out_data.value, out_data.changed, out_data.finished);
        errors++;
      end else begin
        evi_out_t e;
        e = pending_values.pop_front();
        if (e.value !== out_data.value) begin
          $display("%0t: value exp %h act %h", $time, e.value, out_data.value);
          errors++;
        end
        if (e.changed !== out_data.changed) begin
          $display("%0t: changed exp %b act %b", $time, e.changed, out_data.changed);
          errors++;
        end
        if (e.finished !== out_data.finished) begin
          $display("%0t: finished exp %b act %b", $time, e.finished, out_data.finished);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] sv, input logic [31:0] tv,
                           input logic [23:0] dl);
    evi_in_t it;
    it.cmd = cmd;
    it.start_value = sv;
    it.target_value = tv;
    it.delta = dl;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 28);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_values.push_back(advance_value(it));
    items_sent++;
  endtask

  task automatic tick(input logic [23:0] dl);
    send_item(CMD_TICK, $urandom(), $urandom(), dl);
  endtask

  task automatic start_run(input logic [31:0] sv, input logic [31:0] tv);
    send_item(CMD_START, sv, tv, 24'($urandom()));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CURVE_MODE) curve_sel = val[2:0];
    else rate_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return $urandom();
    endcase
  endfunction

  // start, tick with random deltas set by pace until the run ends (or give up)
  task automatic full_run(input logic [31:0] sv, input logic [31:0] tv, input logic [23:0] pace);
    int n;
    start_run(sv, tv);
    n = 0;
    while (run_active && n < 40) begin
      tick((pace == 0) ? 24'($urandom()) : 24'($urandom_range(pace / 2, pace)));
      n++;
    end
  endtask

  task automatic test_directed();
    tick(24'h00_4000);                       // idle tick
    start_run(32'h8000_0000, 32'h7FFF_FFFF);
    tick(24'h00_0000);                       // zero step still recomputes
    tick(24'h00_8000);
    tick(24'hFF_FFFF);                       // clamp at one
    tick(24'h00_1234);                       // snap
    tick(24'h00_0001);
    start_run(32'h0005_0000, 32'h0005_0000);
    tick(24'hFF_FFFF);
    tick(24'h00_0010);                       // already at target: no change
    start_run(32'h7FFF_FFFF, 32'h8000_0000);
    tick(24'h00_4000);
    start_run(32'h0000_0000, 32'h7FFF_FFFF); // restart mid-run
    tick(24'h55_AAAA);
    tick(24'hAA_5555);
    tick(24'h00_0000);
  endtask

  task automatic test_curves();
    for (int m = 0; m < 8; m++) begin
      write_reg(CFG_CURVE_MODE, {21'($urandom()), 3'(m)});
      full_run(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_4000);
      full_run(pick_value(), pick_value(), 24'h00_2000);
    end
  endtask

  task automatic test_rates();
    write_reg(CFG_CURVE_MODE, {21'd0, CURVE_SIN2X});
    write_reg(CFG_RATE, 24'h00_0000);
    full_run(32'h0001_0000, 32'hFFFF_0000, 24'hFF_FFFF);
    write_reg(CFG_RATE, 24'hFF_FFFF);
    full_run(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0100);
    write_reg(CFG_RATE, 24'h00_0001);
    full_run(32'h1234_5678, 32'h8765_4321, 24'hFF_FFFF);
  endtask

  task automatic test_random();
    int budget, phase;
    bit paused;
    budget = RANDOM_ITEMS;
    phase = 0;
    paused = 1'b0;
    while (items_sent < budget) begin
      if (items_sent > 200 + phase * 250) begin
        phase++;
        write_reg(CFG_CURVE_MODE, 24'($urandom()));
        write_reg(CFG_RATE, ($urandom_range(3) == 0) ? 24'($urandom())
                                                     : 24'($urandom_range(16384, 262144)));
        steady = (phase == 3);
      end
      if (!paused && items_sent > 1000) begin
        wait_drained();                      // hold until every result is back
        paused = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:7]:   tick(24'($urandom()));      // noise tick, may land while idle
        [8:12]:  start_run(pick_value(), pick_value());
        default: full_run(pick_value(), pick_value(),
                          ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(256, 24000)));
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int k = 0; k <= SINE_ROM_ENTRIES; k++)
      sine_q30[k] = 31'(series_sine((HALF_PI_TB * k) / SINE_ROM_ENTRIES));
    curve_sel = CURVE_LINEAR;
    rate_q = 24'd65536;
    run_active = 1'b0;
    progress_q = 0;
    origin_q = '0;
    goal_q = '0;
    present_q = '0;
    span_q = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_curves();
    test_rates();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
